### rtl/mbsp_pkg.sv
// Shared types and constants for the MIDI byte stream parser.
package mbsp_pkg;

  typedef enum logic [3:0] {
    KIND_NOTEOFF    = 4'd0,
    KIND_NOTEON     = 4'd1,
    KIND_POLYTOUCH  = 4'd2,
    KIND_CONTROL    = 4'd3,
    KIND_PROGRAM    = 4'd4,
    KIND_CHANTOUCH  = 4'd5,
    KIND_PITCHBEND  = 4'd6,
    KIND_SYSEX_BYTE = 4'd7,
    KIND_SYSEX_END  = 4'd8,
    KIND_CLOCK      = 4'd9,
    KIND_START      = 4'd10,
    KIND_CONTINUE   = 4'd11,
    KIND_STOP       = 4'd12,
    KIND_SENSING    = 4'd13
  } msg_kind_e;

  localparam logic [7:0] ByteSysexStart = 8'hF0;
  localparam logic [7:0] ByteClock      = 8'hF8;
  localparam logic [7:0] ByteStart      = 8'hFA;
  localparam logic [7:0] ByteContinue   = 8'hFB;
  localparam logic [7:0] ByteStop       = 8'hFC;
  localparam logic [7:0] ByteSensing    = 8'hFE;

  localparam logic [3:0] NibNoteOff   = 4'h8;
  localparam logic [3:0] NibProgram   = 4'hC;
  localparam logic [3:0] NibChanTouch = 4'hD;
  localparam logic [3:0] NibSystem    = 4'hF;

  localparam int unsigned MDataW = 24;

  typedef struct packed {
    logic [7:0] running_status;
    logic       have_first_data;
    logic [6:0] first_data_held;
    logic       in_sysex;
  } parse_state_t;

  typedef struct packed {
    msg_kind_e  kind;
    logic [3:0] channel;
    logic [6:0] data_first;
    logic [6:0] data_second;
  } msg_t;

endpackage

### rtl/mbsp_decode.sv
// Combinational decode of one MIDI byte against the parser state.
module mbsp_decode import mbsp_pkg::*; (
  input  logic [7:0]   byte_i,
  input  parse_state_t state_i,
  output parse_state_t state_o,
  output logic         msg_valid_o,
  output msg_t         msg_o
);

  logic [3:0] rs_nib;

  assign rs_nib = state_i.running_status[7:4];

  always_comb begin
    state_o     = state_i;
    msg_valid_o = 1'b0;
    msg_o       = '{kind: KIND_NOTEOFF, channel: 4'd0, data_first: 7'd0, data_second: 7'd0};

    if (state_i.in_sysex) begin
      msg_valid_o = 1'b1;
      if (!byte_i[7]) begin
        msg_o.kind       = KIND_SYSEX_BYTE;
        msg_o.data_first = byte_i[6:0];
      end else begin
        // any status ends the transfer and is dropped
        msg_o.kind       = KIND_SYSEX_END;
        state_o.in_sysex = 1'b0;
      end
    end else if (byte_i[7]) begin
      unique case (byte_i)
        ByteClock: begin
          msg_valid_o = 1'b1;
          msg_o.kind  = KIND_CLOCK;
        end
        ByteStart: begin
          msg_valid_o = 1'b1;
          msg_o.kind  = KIND_START;
        end
        ByteContinue: begin
          msg_valid_o = 1'b1;
          msg_o.kind  = KIND_CONTINUE;
        end
        ByteStop: begin
          msg_valid_o = 1'b1;
          msg_o.kind  = KIND_STOP;
        end
        ByteSensing: begin
          msg_valid_o = 1'b1;
          msg_o.kind  = KIND_SENSING;
        end
        default: begin
          state_o.running_status  = byte_i;
          state_o.have_first_data = 1'b0;
          state_o.in_sysex        = (byte_i == ByteSysexStart);
        end
      endcase
    end else if (state_i.running_status[7] && rs_nib != NibSystem) begin
      msg_o.kind    = msg_kind_e'(rs_nib - NibNoteOff);
      msg_o.channel = state_i.running_status[3:0];
      if (rs_nib == NibProgram || rs_nib == NibChanTouch) begin
        msg_valid_o      = 1'b1;
        msg_o.data_first = byte_i[6:0];
      end else if (!state_i.have_first_data) begin
        state_o.first_data_held = byte_i[6:0];
        state_o.have_first_data = 1'b1;
      end else begin
        state_o.have_first_data = 1'b0;
        msg_valid_o             = 1'b1;
        msg_o.data_first        = state_i.first_data_held;
        msg_o.data_second       = byte_i[6:0];
      end
    end
  end

endmodule

### rtl/midi_byte_stream_parser.sv
// Top level of the MIDI byte stream parser with running status.
//
// Slave channel s_*: one received MIDI byte per word on s_tdata_i.
// Master channel m_*: one decoded message per word, kind on m_tuser_o,
// channel and data bytes on m_tdata_o.
// A byte is first captured in an input register; the decode logic then
// updates the running status and, when a message completes, loads the
// result register, which drives the output. One byte is taken per
// cycle, sustained, while the receiver keeps up; bytes that complete
// no message (status, first data bytes, ignored data) leave no word
// behind.
// When the receiver stalls, the held message waits in the result register
// and the pipeline stops once the input register is also full; ready then
// drops, nothing is lost.
// Reset clears both stages and the parser state: no running status, no
// held data byte, not in system exclusive.
module midi_byte_stream_parser import mbsp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_tvalid_i,
  output logic              s_tready_o,
  input  logic [7:0]        s_tdata_i,   // [7:0] byte_in
  output logic              m_tvalid_o,
  input  logic              m_tready_i,
  output logic [MDataW-1:0] m_tdata_o,   // [3:0] channel, [10:4] data_first,
                                         // [17:11] data_second, [23:18] zero
  output logic [3:0]        m_tuser_o    // [3:0] message_kind
);

  logic         in_valid_q, in_valid_d;
  logic [7:0]   in_byte_q;
  parse_state_t state_q, state_d;
  logic         out_valid_q, out_valid_d;
  msg_t         out_msg_q;

  logic         dec_valid;
  msg_t         dec_msg;
  logic         advance;
  logic         s_fire;

  mbsp_decode u_decode (
    .byte_i      (in_byte_q),
    .state_i     (state_q),
    .state_o     (state_d),
    .msg_valid_o (dec_valid),
    .msg_o       (dec_msg)
  );

  // the input word moves on once the result register is free or emptying
  assign advance    = in_valid_q && (!out_valid_q || m_tready_i);
  assign s_tready_o = !in_valid_q || advance;
  assign s_fire     = s_tvalid_i && s_tready_o;

  always_comb begin
    in_valid_d  = s_fire ? 1'b1 : (advance ? 1'b0 : in_valid_q);
    out_valid_d = advance ? dec_valid : (m_tready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_byte_q <= s_tdata_i;
    end
    if (advance && dec_valid) begin
      out_msg_q <= dec_msg;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tuser_o  = out_msg_q.kind;
  assign m_tdata_o  = {{(MDataW - 18){1'b0}}, out_msg_q.data_second,
                       out_msg_q.data_first, out_msg_q.channel};

  a_sys_channel_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && out_msg_q.kind >= KIND_SYSEX_BYTE |-> out_msg_q.channel == 4'd0)
    else $error("system event with nonzero channel");

  a_sysex_status : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.in_sysex |-> state_q.running_status == ByteSysexStart)
    else $error("sysex flag without sysex status");

  a_held_needs_two_byte : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.have_first_data |-> state_q.running_status[7] &&
      state_q.running_status[7:4] != NibProgram &&
      state_q.running_status[7:4] != NibChanTouch &&
      state_q.running_status[7:4] != NibSystem)
    else $error("held data byte without two-byte channel status");

  a_stall_holds_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !m_tready_i |=> $stable(state_q))
    else $error("parser state moved while result stalled");

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the MIDI byte stream parser: byte stream stimulus and decode check.
module testbench;
  import mbsp_pkg::*;

  typedef struct {
    logic [7:0] midi_byte;
    bit         drain_first;  // hold off until every queued message has come out
  } tx_byte_t;

  logic              clk_i      = 1'b0;
  logic              rst_ni     = 1'b0;
  logic              s_tvalid_i = 1'b0;
  logic              s_tready_o;
  logic [7:0]        s_tdata_i  = 8'h00;   // [7:0] byte_in
  logic              m_tvalid_o;
  logic              m_tready_i = 1'b0;
  logic [MDataW-1:0] m_tdata_o;            // [3:0] channel, [10:4] data_first,
                                           // [17:11] data_second, [23:18] zero
  logic [3:0]        m_tuser_o;            // [3:0] message_kind

  tx_byte_t tx_q[$];
  msg_t     msg_exp_q[$];

  // parser state as the predictor sees it
  logic [7:0] pr_status     = 8'h00;
  logic       pr_have_first = 1'b0;
  logic [6:0] pr_first      = 7'h00;
  logic       pr_sysex      = 1'b0;

  logic [7:0]  gen_status = 8'h00;
  int unsigned err_cnt    = 0;
  int unsigned bytes_sent = 0;
  int unsigned msgs_seen  = 0;
  int unsigned gap_left   = 0;
  int unsigned stall_left = 0;
  bit          in_taken   = 1'b0;
  bit          out_taken  = 1'b0;
  bit          out_seen   = 1'b0;

  midi_byte_stream_parser u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tuser_o  (m_tuser_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  task automatic report(input string what);
    err_cnt++;
    $display("%0t ns: %s", $time, what);
  endtask

  // Works out the message, if any, that one received byte completes.
  task automatic decode_midi_byte(input logic [7:0] b);
    msg_t m;
    m = '0;
    if (pr_sysex) begin
      if (!b[7]) begin
        m.kind       = KIND_SYSEX_BYTE;
        m.data_first = b[6:0];
      end else begin
        // any status byte, real-time too, closes the transfer and is dropped
        pr_sysex = 1'b0;
        m.kind   = KIND_SYSEX_END;
      end
      msg_exp_q.push_back(m);
    end else if (b[7]) begin
      case (b)
        ByteClock: begin
          m.kind = KIND_CLOCK;
          msg_exp_q.push_back(m);
        end
        ByteStart: begin
          m.kind = KIND_START;
          msg_exp_q.push_back(m);
        end
        ByteContinue: begin
          m.kind = KIND_CONTINUE;
          msg_exp_q.push_back(m);
        end
        ByteStop: begin
          m.kind = KIND_STOP;
          msg_exp_q.push_back(m);
        end
        ByteSensing: begin
          m.kind = KIND_SENSING;
          msg_exp_q.push_back(m);
        end
        default: begin
          pr_status     = b;
          pr_have_first = 1'b0;
          pr_sysex      = (b == ByteSysexStart);
        end
      endcase
    end else if (pr_status[7] && pr_status[7:4] != NibSystem) begin
      m.kind    = msg_kind_e'(pr_status[7:4] - NibNoteOff);
      m.channel = pr_status[3:0];
      if (pr_status[7:4] == NibProgram || pr_status[7:4] == NibChanTouch) begin
        m.data_first = b[6:0];
        msg_exp_q.push_back(m);
      end else if (!pr_have_first) begin
        pr_first      = b[6:0];
        pr_have_first = 1'b1;
      end else begin
        pr_have_first = 1'b0;
        m.data_first  = pr_first;
        m.data_second = b[6:0];
        msg_exp_q.push_back(m);
      end
    end
  endtask

  function automatic logic [7:0] realtime_byte();
    case ($urandom_range(0, 4))
      0:       return ByteClock;
      1:       return ByteStart;
      2:       return ByteContinue;
      3:       return ByteStop;
      default: return ByteSensing;
    endcase
  endfunction

  task automatic push_byte(input logic [7:0] b);
    tx_byte_t t;
    t.midi_byte   = b;
    t.drain_first = 1'b0;
    tx_q.push_back(t);
  endtask

  // One random sequence: mostly well-formed channel messages, some sysex,
  // real-time, system common and plain noise.
  task automatic add_random_seq();
    int unsigned pick;
    int unsigned n;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      if (!gen_status[7] || $urandom_range(0, 3) != 0) begin
        gen_status = 8'h80 | 8'($urandom_range(0, 8'h6F));
        push_byte(gen_status);
      end
      n = (gen_status[7:4] == NibProgram || gen_status[7:4] == NibChanTouch) ? 1 : 2;
      repeat (n) begin
        if ($urandom_range(0, 9) == 0) push_byte(realtime_byte());
        push_byte(8'($urandom_range(0, 127)));
      end
    end else if (pick < 72) begin
      push_byte(ByteSysexStart);
      repeat ($urandom_range(0, 6)) push_byte(8'($urandom_range(0, 127)));
      push_byte(($urandom_range(0, 1) != 0) ? 8'hF7 : 8'($urandom_range(128, 255)));
      gen_status = 8'h00;
    end else if (pick < 82) begin
      push_byte(realtime_byte());
    end else if (pick < 90) begin
      push_byte(8'($urandom_range(8'hF1, 8'hFF)));
      if ($urandom_range(0, 1) != 0) push_byte(8'($urandom_range(0, 127)));
      gen_status = 8'h00;
    end else begin
      push_byte(8'($urandom_range(0, 255)));
      gen_status = 8'h00;
    end
  endtask

  // Sender: new word at the falling edge once the previous one was taken.
  always @(negedge clk_i) begin : driver
    logic       nv;
    logic [7:0] nd;
    nv = s_tvalid_i;
    nd = s_tdata_i;
    if (in_taken) begin
      in_taken = 1'b0;
      nv       = 1'b0;
    end
    if (rst_ni && !nv) begin
      if (gap_left != 0) begin
        gap_left--;
      end else if (tx_q.size() != 0 && !(tx_q[0].drain_first && msg_exp_q.size() != 0)) begin
        nd = tx_q[0].midi_byte;
        void'(tx_q.pop_front());
        nv = 1'b1;
        gap_left = ((bytes_sent / 40) % 3 == 0) ? 0 : $urandom_range(0, 19);
      end
    end
    s_tvalid_i <= nv;
    s_tdata_i  <= nd;
  end

  // Receiver: stall drawn per message, counted down only while a word waits.
  always @(negedge clk_i) begin : sink
    logic rdy;
    if (out_taken) begin
      out_taken  = 1'b0;
      stall_left = ((msgs_seen / 30) % 3 == 0) ? 0 : $urandom_range(0, 19);
    end
    if (stall_left == 0) begin
      rdy = 1'b1;
    end else begin
      rdy = 1'b0;
      if (out_seen) stall_left--;
    end
    m_tready_i <= rst_ni && rdy;
  end

  always @(posedge clk_i) begin : monitor
    msg_t want;
    if (rst_ni) begin
      if (s_tvalid_i && s_tready_o) begin
        decode_midi_byte(s_tdata_i);
        bytes_sent++;
        in_taken = 1'b1;
      end
      out_seen = m_tvalid_o;
      if (m_tvalid_o && m_tready_i) begin
        out_taken = 1'b1;
        msgs_seen++;
        if (msg_exp_q.size() == 0) begin
          report($sformatf("unexpected word: kind %0d tdata %h", m_tuser_o, m_tdata_o));
        end else begin
          want = msg_exp_q.pop_front();
          if (m_tuser_o !== want.kind)
            report($sformatf("kind: got %0d, want %0d", m_tuser_o, want.kind));
          if (m_tdata_o[3:0] !== want.channel)
            report($sformatf("channel: got %0d, want %0d", m_tdata_o[3:0], want.channel));
          if (m_tdata_o[10:4] !== want.data_first)
            report($sformatf("data_first: got %h, want %h", m_tdata_o[10:4],
                             want.data_first));
          if (m_tdata_o[17:11] !== want.data_second)
            report($sformatf("data_second: got %h, want %h", m_tdata_o[17:11],
                             want.data_second));
          if (m_tdata_o[MDataW-1:18] !== '0)
            report($sformatf("padding bits not zero: %h", m_tdata_o));
        end
      end
    end
  end

  initial begin : stimulus
    logic [7:0] directed [27] = '{
      8'h00,                          // data with no status yet
      8'h90, 8'h00, 8'h7F,            // note on, data extremes
      8'h7F, 8'h00,                   // running status
      8'h8F, 8'h3C, 8'hF8, 8'h40,     // clock between the data bytes
      8'hC5, 8'h12,                   // program change
      8'hD3, 8'h7F,                   // channel aftertouch
      8'hA0, 8'h10, 8'hB7, 8'h11, 8'h22, // new status drops held byte
      8'hE9, 8'h01, 8'h02,            // pitch bend
      8'hF0, 8'h55, 8'hFE,            // sysex ended by a real-time byte
      8'h05,                          // ignored after sysex
      8'hFF
    };
    foreach (directed[i]) push_byte(directed[i]);
    tx_q[22].drain_first = 1'b1;
    while (tx_q.size() < 480) add_random_seq();
    tx_q[200].drain_first = 1'b1;
    tx_q[400].drain_first = 1'b1;

    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    while (tx_q.size() != 0 || s_tvalid_i || msg_exp_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
